/* rtl/core/gbns_pkg.sv */
// Package for the go-back-N sender core.
// Holds the event, mode, status and sequencer types and the default depths.
// No dependencies.
package gbns_pkg;

    localparam int HANDLE_W          = 16;
    localparam int WINDOW_DEPTH_DEF  = 64;
    localparam int WAIT_DEPTH_DEF    = 64;

    typedef enum logic [1:0] {
        EV_NEW     = 2'd0,
        EV_TX_DONE = 2'd1,
        EV_ACK     = 2'd2,
        EV_NACK    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NEW    = 2'd1,
        MODE_RESEND = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_WAIT_FULL  = 3'd1,
        ST_WIN_FULL   = 3'd2,
        ST_ACK_IGN    = 3'd3,
        ST_NACK_IGN   = 3'd4
    } t_status;

    typedef enum logic {
        ENG_DECODE = 1'b0,
        ENG_EXEC   = 1'b1
    } t_eng_state;

    typedef struct packed {
        t_kind                 kind;
        logic [HANDLE_W-1:0]   handle;
    } t_event;

endpackage

/* rtl/core/gbns_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/gbns_fifo.sv */
// Two-entry queue used between the front end, the sequencer and the result port.
// No dependencies.
module gbns_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/gbns_front.sv */
// Front end: accepts event items, decodes the kind and queues them for the sequencer.
// Depends on gbns_pkg and gbns_fifo.
module gbns_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    input  logic [1:0]                         i_event_kind,
    input  logic [gbns_pkg::HANDLE_W-1:0]      i_packet_handle,
    output logic                               full,
    input  logic                               i_take,
    output gbns_pkg::t_event                   o_evt,
    output logic                               o_evt_valid
);
    import gbns_pkg::*;

    localparam int EW = $bits(t_event);

    t_event          evt_in;
    logic [EW-1:0]   q_data;
    logic            q_empty;

    always_comb begin
        evt_in.kind   = t_kind'(i_event_kind);
        evt_in.handle = (t_kind'(i_event_kind) == EV_NEW) ? i_packet_handle : '0;
    end

    gbns_fifo #(.WIDTH(EW)) u_evt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (evt_in),
        .o_full  (full),
        .i_pop   (i_take),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_evt       = t_event'(q_data);
    assign o_evt_valid = !q_empty;

endmodule

/* rtl/core/gbns_engine.sv */
// Back end: window and wait stores, the go-back-N sequencer and the result queue.
// Depends on gbns_pkg, gbns_ram and gbns_fifo.
module gbns_engine #(
    parameter int WINDOW_DEPTH = gbns_pkg::WINDOW_DEPTH_DEF,
    parameter int WAIT_DEPTH   = gbns_pkg::WAIT_DEPTH_DEF,
    parameter int RES_W        = 23 + $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbns_pkg::t_event    i_evt,
    input  logic                i_evt_valid,
    output logic                o_evt_take,
    input  logic                i_res_pop,
    output logic [RES_W-1:0]    o_res_data,
    output logic                o_res_empty
);
    import gbns_pkg::*;

    localparam int UAW = $clog2(WINDOW_DEPTH);
    localparam int UCW = $clog2(WINDOW_DEPTH + 1);
    localparam int USW = UCW + 1;
    localparam int WAW = $clog2(WAIT_DEPTH);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);
    localparam int WSW = WCW + 1;

    localparam logic [UCW-1:0] UN_FULL  = UCW'(WINDOW_DEPTH);
    localparam logic [USW-1:0] UN_WRAP  = USW'(WINDOW_DEPTH);
    localparam logic [UAW-1:0] UN_LAST  = UAW'(WINDOW_DEPTH - 1);
    localparam logic [WCW-1:0] WT_FULL  = WCW'(WAIT_DEPTH);
    localparam logic [WSW-1:0] WT_WRAP  = WSW'(WAIT_DEPTH);
    localparam logic [WAW-1:0] WT_LAST  = WAW'(WAIT_DEPTH - 1);

    t_eng_state          r_state, n_state;
    t_event              r_evt;
    t_mode               r_mode, n_mode;
    logic [UAW-1:0]      r_un_head, n_un_head;
    logic [UCW-1:0]      r_un_count, n_un_count;
    logic [WAW-1:0]      r_wt_head, n_wt_head;
    logic [WCW-1:0]      r_wt_count, n_wt_count;
    logic [UCW-1:0]      r_rs_index, n_rs_index;
    logic [UCW-1:0]      r_rs_total, n_rs_total;

    logic                res_full;
    logic                res_push;
    logic [RES_W-1:0]    res_data;

    logic [USW-1:0]      un_rsum;
    logic [UAW-1:0]      un_raddr;
    logic [USW-1:0]      un_tsum;
    logic [UAW-1:0]      un_tail;
    logic [WSW-1:0]      wt_tsum;
    logic [WAW-1:0]      wt_tail;
    logic [HANDLE_W-1:0] un_rdata;
    logic [HANDLE_W-1:0] wt_rdata;

    logic                un_we;
    logic [HANDLE_W-1:0] un_wdata;
    logic                wt_we;

    logic                sent;
    logic                resend;
    logic [HANDLE_W-1:0] handle;
    t_status             status;
    logic                do_serve;

    // The window read address comes from the event at the head of the front queue.
    always_comb begin
        un_rsum = USW'(r_un_head)
                + ((i_evt.kind == EV_NACK) ? '0 : {1'b0, r_rs_index});
        if (un_rsum >= UN_WRAP) begin
            un_rsum = un_rsum - UN_WRAP;
        end
        un_raddr = un_rsum[UAW-1:0];

        un_tsum = USW'(r_un_head) + USW'(r_un_count);
        if (un_tsum >= UN_WRAP) begin
            un_tsum = un_tsum - UN_WRAP;
        end
        un_tail = un_tsum[UAW-1:0];

        wt_tsum = WSW'(r_wt_head) + WSW'(r_wt_count);
        if (wt_tsum >= WT_WRAP) begin
            wt_tsum = wt_tsum - WT_WRAP;
        end
        wt_tail = wt_tsum[WAW-1:0];
    end

    gbns_ram #(.WIDTH(HANDLE_W), .DEPTH(WINDOW_DEPTH)) u_unacked_ram (
        .i_clk   (i_clk),
        .i_we    (un_we),
        .i_waddr (un_tail),
        .i_wdata (un_wdata),
        .i_raddr (un_raddr),
        .o_rdata (un_rdata)
    );

    gbns_ram #(.WIDTH(HANDLE_W), .DEPTH(WAIT_DEPTH)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_tail),
        .i_wdata (r_evt.handle),
        .i_raddr (r_wt_head),
        .o_rdata (wt_rdata)
    );

    assign o_evt_take = (r_state == ENG_DECODE) && i_evt_valid && !res_full;
    assign res_push   = (r_state == ENG_EXEC);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_un_head  = r_un_head;
        n_un_count = r_un_count;
        n_wt_head  = r_wt_head;
        n_wt_count = r_wt_count;
        n_rs_index = r_rs_index;
        n_rs_total = r_rs_total;
        un_we      = 1'b0;
        un_wdata   = r_evt.handle;
        wt_we      = 1'b0;
        sent       = 1'b0;
        resend     = 1'b0;
        handle     = '0;
        status     = ST_OK;
        do_serve   = 1'b0;

        case (r_state)
            ENG_DECODE: begin
                if (o_evt_take) begin
                    n_state = ENG_EXEC;
                end
            end
            ENG_EXEC: begin
                n_state = ENG_DECODE;
                case (r_evt.kind)
                    EV_NEW: begin
                        if (r_mode == MODE_IDLE) begin
                            if (r_un_count != UN_FULL) begin
                                un_we      = 1'b1;
                                n_un_count = r_un_count + 1'b1;
                                sent       = 1'b1;
                                handle     = r_evt.handle;
                                n_mode     = MODE_NEW;
                            end else begin
                                status = ST_WIN_FULL;
                            end
                        end else if (r_wt_count == WT_FULL) begin
                            status = ST_WAIT_FULL;
                        end else begin
                            wt_we      = 1'b1;
                            n_wt_count = r_wt_count + 1'b1;
                        end
                    end
                    EV_TX_DONE: begin
                        if (r_mode == MODE_NEW) begin
                            do_serve = 1'b1;
                        end else if (r_mode == MODE_RESEND) begin
                            if (r_rs_index >= r_rs_total || r_rs_index >= r_un_count) begin
                                do_serve = 1'b1;
                            end else begin
                                sent       = 1'b1;
                                resend     = 1'b1;
                                handle     = un_rdata;
                                n_rs_index = r_rs_index + 1'b1;
                            end
                        end
                    end
                    EV_ACK: begin
                        if (r_un_count == '0) begin
                            status = ST_ACK_IGN;
                        end else begin
                            n_un_head  = (r_un_head == UN_LAST) ? '0 : r_un_head + 1'b1;
                            n_un_count = r_un_count - 1'b1;
                            if (r_rs_index != '0) begin
                                n_rs_index = r_rs_index - 1'b1;
                            end
                            if (r_rs_total != '0) begin
                                n_rs_total = r_rs_total - 1'b1;
                            end
                        end
                    end
                    EV_NACK: begin
                        if (r_un_count == '0) begin
                            status = ST_NACK_IGN;
                        end else begin
                            n_rs_total = r_un_count;
                            n_rs_index = '0;
                            if (r_mode == MODE_IDLE) begin
                                sent       = 1'b1;
                                resend     = 1'b1;
                                handle     = un_rdata;
                                n_rs_index = UCW'(1);
                            end
                            n_mode = MODE_RESEND;
                        end
                    end
                    default: begin
                    end
                endcase

                if (do_serve) begin
                    if (r_wt_count == '0) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_wt_head  = (r_wt_head == WT_LAST) ? '0 : r_wt_head + 1'b1;
                        n_wt_count = r_wt_count - 1'b1;
                        if (r_un_count == UN_FULL) begin
                            status = ST_WIN_FULL;
                            n_mode = MODE_IDLE;
                        end else begin
                            un_we      = 1'b1;
                            un_wdata   = wt_rdata;
                            n_un_count = r_un_count + 1'b1;
                            sent       = 1'b1;
                            handle     = wt_rdata;
                            n_mode     = MODE_NEW;
                        end
                    end
                end
            end
            default: begin
                n_state = ENG_DECODE;
            end
        endcase
    end

    assign res_data = {sent, handle, resend, status, n_mode, n_un_count};

    always_ff @(posedge i_clk) begin
        if (o_evt_take) begin
            r_evt <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ENG_DECODE;
            r_mode     <= MODE_IDLE;
            r_un_head  <= '0;
            r_un_count <= '0;
            r_wt_head  <= '0;
            r_wt_count <= '0;
            r_rs_index <= '0;
            r_rs_total <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_un_head  <= n_un_head;
            r_un_count <= n_un_count;
            r_wt_head  <= n_wt_head;
            r_wt_count <= n_wt_count;
            r_rs_index <= n_rs_index;
            r_rs_total <= n_rs_total;
        end
    end

    gbns_fifo #(.WIDTH(RES_W)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res_data),
        .o_empty (o_res_empty)
    );

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_un_count <= UN_FULL)
        else $error("Unacked count exceeds the window depth.");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wt_count <= WT_FULL)
        else $error("Wait count exceeds the wait depth.");

    a_resend_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rs_index <= r_un_count && r_rs_total <= r_un_count)
        else $error("Resend pointers run past the unacked window.");

    a_exec_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_take |=> (r_state == ENG_EXEC))
        else $error("Accepted item was not executed in the next cycle.");

    a_no_room_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ENG_EXEC) |-> !res_full)
        else $error("Result produced while the result queue is full.");

endmodule

/* rtl/core/go_back_n_sender_core.sv */
// Top level of the go-back-N sender core.
// Depends on gbns_pkg, gbns_front and gbns_engine.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------------------
//  Event    | push in, full out         | i_event_kind, i_packet_handle
//  Result   | empty out, pop in         | o_send_valid, o_send_handle, o_is_resend,
//           |                           | o_event_status, o_sender_mode, o_outstanding
//
// Each item passes through the sequencer states DECODE, which reads the window and wait
// RAMs (registered read port), and EXEC, which executes and writes the result.
// The sequencer accepts a new item only once it has executed the last one; each result
// reaches the outputs through the result queue.
// Reset is synchronous and clears control state only; the RAMs need no clearing.
// Two-entry queues on each side let the input and result sides stall independently.
module go_back_n_sender_core #(
    parameter int WINDOW_DEPTH = gbns_pkg::WINDOW_DEPTH_DEF,
    parameter int WAIT_DEPTH   = gbns_pkg::WAIT_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [1:0]                             i_event_kind,
    input  logic [gbns_pkg::HANDLE_W-1:0]          i_packet_handle,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_send_valid,
    output logic [gbns_pkg::HANDLE_W-1:0]          o_send_handle,
    output logic                                   o_is_resend,
    output logic [2:0]                             o_event_status,
    output logic [1:0]                             o_sender_mode,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]      o_outstanding
);
    import gbns_pkg::*;

    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int RES_W = 23 + CW;

    t_event              evt;
    logic                evt_valid;
    logic                evt_take;
    logic [RES_W-1:0]    res;

    gbns_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .i_event_kind    (i_event_kind),
        .i_packet_handle (i_packet_handle),
        .full            (full),
        .i_take          (evt_take),
        .o_evt           (evt),
        .o_evt_valid     (evt_valid)
    );

    gbns_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .WAIT_DEPTH   (WAIT_DEPTH),
        .RES_W        (RES_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_evt_valid (evt_valid),
        .o_evt_take  (evt_take),
        .i_res_pop   (pop),
        .o_res_data  (res),
        .o_res_empty (empty)
    );

    assign o_outstanding  = res[CW-1:0];
    assign o_sender_mode  = res[CW+1:CW];
    assign o_event_status = res[CW+4:CW+2];
    assign o_is_resend    = res[CW+5];
    assign o_send_handle  = res[CW+21:CW+6];
    assign o_send_valid   = res[CW+22];

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for go_back_n_sender_core: drives event items, predicts each result item.
// Depends on gbns_pkg and the go_back_n_sender_core RTL.
module tb_top;
    import gbns_pkg::*;

    localparam int WIN_D   = WINDOW_DEPTH_DEF;
    localparam int WAIT_D  = WAIT_DEPTH_DEF;
    localparam int OUT_W   = $clog2(WIN_D + 1);
    localparam int LIMIT   = 200000;

    typedef struct {
        logic                send_valid;
        logic [HANDLE_W-1:0] handle;
        logic                resend;
        t_status             status;
        t_mode               mode;
        logic [OUT_W-1:0]    outstanding;
    } t_sender_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [1:0]            i_event_kind = 2'd0;
    logic [HANDLE_W-1:0]   i_packet_handle = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_send_valid;
    logic [HANDLE_W-1:0]   o_send_handle;
    logic                  o_is_resend;
    logic [2:0]            o_event_status;
    logic [1:0]            o_sender_mode;
    logic [OUT_W-1:0]      o_outstanding;

    t_sender_result pending_results[$];
    int  errors = 0;
    int  cycle_count = 0;
    int  pop_stall = 0;
    bit  in_idle_en = 1'b1;
    bit  out_idle_en = 1'b1;

    t_mode               m_mode = MODE_IDLE;
    logic [HANDLE_W-1:0] win_mem [WIN_D];
    int                  win_head = 0;
    int                  win_cnt = 0;
    logic [HANDLE_W-1:0] wq_mem [WAIT_D];
    int                  wq_head = 0;
    int                  wq_cnt = 0;
    int                  rs_idx = 0;
    int                  rs_total = 0;

    go_back_n_sender_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_event_kind    (i_event_kind),
        .i_packet_handle (i_packet_handle),
        .empty           (empty),
        .pop             (pop),
        .o_send_valid    (o_send_valid),
        .o_send_handle   (o_send_handle),
        .o_is_resend     (o_is_resend),
        .o_event_status  (o_event_status),
        .o_sender_mode   (o_sender_mode),
        .o_outstanding   (o_outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit window_insert(logic [HANDLE_W-1:0] h);
        if (win_cnt >= WIN_D) return 1'b0;
        win_mem[(win_head + win_cnt) % WIN_D] = h;
        win_cnt++;
        return 1'b1;
    endfunction

    function automatic void serve_wait_fifo(inout t_sender_result r);
        logic [HANDLE_W-1:0] h;
        if (wq_cnt == 0) begin
            m_mode = MODE_IDLE;
            return;
        end
        h = wq_mem[wq_head];
        wq_head = (wq_head + 1) % WAIT_D;
        wq_cnt--;
        if (!window_insert(h)) begin
            r.status = ST_WIN_FULL;
            m_mode = MODE_IDLE;
            return;
        end
        r.send_valid = 1'b1;
        r.handle = h;
        m_mode = MODE_NEW;
    endfunction

    function automatic t_sender_result predict_sender(t_kind k, logic [HANDLE_W-1:0] h);
        t_sender_result r;
        r.send_valid = 1'b0;
        r.handle = '0;
        r.resend = 1'b0;
        r.status = ST_OK;
        case (k)
            EV_NEW: begin
                if (m_mode == MODE_IDLE) begin
                    if (window_insert(h)) begin
                        r.send_valid = 1'b1;
                        r.handle = h;
                        m_mode = MODE_NEW;
                    end else begin
                        r.status = ST_WIN_FULL;
                    end
                end else if (wq_cnt >= WAIT_D) begin
                    r.status = ST_WAIT_FULL;
                end else begin
                    wq_mem[(wq_head + wq_cnt) % WAIT_D] = h;
                    wq_cnt++;
                end
            end
            EV_TX_DONE: begin
                if (m_mode == MODE_NEW) begin
                    serve_wait_fifo(r);
                end else if (m_mode == MODE_RESEND) begin
                    if (rs_idx >= rs_total || rs_idx >= win_cnt) begin
                        serve_wait_fifo(r);
                    end else begin
                        r.send_valid = 1'b1;
                        r.resend = 1'b1;
                        r.handle = win_mem[(win_head + rs_idx) % WIN_D];
                        rs_idx++;
                    end
                end
            end
            EV_ACK: begin
                if (win_cnt == 0) begin
                    r.status = ST_ACK_IGN;
                end else begin
                    win_head = (win_head + 1) % WIN_D;
                    win_cnt--;
                    if (rs_idx > 0) rs_idx--;
                    if (rs_total > 0) rs_total--;
                end
            end
            default: begin
                if (win_cnt == 0) begin
                    r.status = ST_NACK_IGN;
                end else begin
                    rs_total = win_cnt;
                    rs_idx = 0;
                    if (m_mode == MODE_IDLE) begin
                        r.send_valid = 1'b1;
                        r.resend = 1'b1;
                        r.handle = win_mem[win_head];
                        rs_idx = 1;
                    end
                    m_mode = MODE_RESEND;
                end
            end
        endcase
        r.mode = m_mode;
        r.outstanding = OUT_W'(win_cnt);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken,
    // with push still high so that back-to-back items need no extra edge.
    task automatic send_event(t_kind k, logic [HANDLE_W-1:0] h);
        if (in_idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_event_kind <= k;
        i_packet_handle <= h;
        do @(posedge i_clk); while (full !== 1'b0);
        pending_results.push_back(predict_sender(k, h));
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_basic();
        send_event(EV_ACK, 16'h0000);
        send_event(EV_NACK, 16'hFFFF);
        send_event(EV_TX_DONE, 16'h1234);
        send_event(EV_NEW, 16'h0000);
        send_event(EV_NEW, 16'hFFFF);
        send_event(EV_NEW, 16'hA5A5);
        send_event(EV_TX_DONE, 16'h5A5A);
        send_event(EV_NACK, 16'h0000);
        send_event(EV_TX_DONE, 16'h0000);
        send_event(EV_ACK, 16'h0000);
        send_event(EV_TX_DONE, 16'h0000);
        send_event(EV_TX_DONE, 16'h0000);
        send_event(EV_TX_DONE, 16'h0000);
        send_event(EV_TX_DONE, 16'h0000);
        send_event(EV_NACK, 16'hFFFF);
        send_event(EV_ACK, 16'hFFFF);
        send_event(EV_ACK, 16'hFFFF);
        send_event(EV_ACK, 16'hFFFF);
        send_event(EV_TX_DONE, 16'hFFFF);
        send_event(EV_TX_DONE, 16'hFFFF);
        wait_results();
    endtask

    task automatic test_window_fill();
        repeat (WIN_D) begin
            send_event(EV_NEW, HANDLE_W'($urandom_range(0, 65535)));
            send_event(EV_TX_DONE, HANDLE_W'($urandom_range(0, 65535)));
        end
        send_event(EV_NEW, HANDLE_W'($urandom_range(0, 65535)));
        send_event(EV_NACK, HANDLE_W'($urandom_range(0, 65535)));
        repeat (WAIT_D + 2) send_event(EV_NEW, HANDLE_W'($urandom_range(0, 65535)));
        repeat (WIN_D + 2) send_event(EV_TX_DONE, HANDLE_W'($urandom_range(0, 65535)));
        repeat (WIN_D + 6) send_event(EV_ACK, HANDLE_W'($urandom_range(0, 65535)));
        wait_results();
    endtask

    task automatic test_random_traffic(int n);
        int    pick;
        t_kind k;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) k = EV_NEW;
            else if (pick < 70) k = EV_TX_DONE;
            else if (pick < 90) k = EV_ACK;
            else k = EV_NACK;
            send_event(k, HANDLE_W'($urandom_range(0, 65535)));
        end
        wait_results();
    endtask

    always @(negedge i_clk) begin
        if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            pop_stall = $urandom_range(1, 16) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sender_result exp_r;
        if (i_rst_n && pop && empty === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no item pending");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_send_valid !== exp_r.send_valid) begin
                    $error("send_valid: expected %0d, actual %0d", exp_r.send_valid, o_send_valid);
                    errors++;
                end
                if (o_send_handle !== exp_r.handle) begin
                    $error("send_handle: expected %h, actual %h", exp_r.handle, o_send_handle);
                    errors++;
                end
                if (o_is_resend !== exp_r.resend) begin
                    $error("is_resend: expected %0d, actual %0d", exp_r.resend, o_is_resend);
                    errors++;
                end
                if (o_event_status !== exp_r.status) begin
                    $error("event_status: expected %0d, actual %0d", exp_r.status,
                           o_event_status);
                    errors++;
                end
                if (o_sender_mode !== exp_r.mode) begin
                    $error("sender_mode: expected %0d, actual %0d", exp_r.mode, o_sender_mode);
                    errors++;
                end
                if (o_outstanding !== exp_r.outstanding) begin
                    $error("outstanding: expected %0d, actual %0d", exp_r.outstanding,
                           o_outstanding);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic();
        test_window_fill();
        test_random_traffic(120);
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        test_random_traffic(80);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
